### design/triplet_margin_loss_with_gradient_macros.svh
// ----------------------------------------------------------------------------
// triplet margin loss assertion macros
// shared property templates for the block checks
// ----------------------------------------------------------------------------
`ifndef TRIPLET_MARGIN_LOSS_WITH_GRADIENT_MACROS_SVH
`define TRIPLET_MARGIN_LOSS_WITH_GRADIENT_MACROS_SVH

// same-cycle implication
`define TML_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TML_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tml_pkg.sv
// ----------------------------------------------------------------------------
// tml_pkg
// types and constants shared by the triplet margin loss modules
// ----------------------------------------------------------------------------
package tml_pkg;

    localparam int VAL_W   = 16;
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 34;
    localparam int DIST_W  = 40;
    localparam int LOSS_W  = 41;
    localparam int GRAD_W  = 20;
    localparam int CNT_W   = 6;
    localparam int APB_DW  = 64;
    localparam int APB_AW  = 3;

    localparam logic [APB_AW-1:0] ADDR_MARGIN  = 3'd0;
    localparam logic [DIST_W-1:0] MARGIN_RESET = 40'd65536;

    localparam logic KIND_LOSS = 1'b0;
    localparam logic KIND_GRAD = 1'b1;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dp;
        logic signed [DIFF_W-1:0] dn;
    } t_diff_pair;

    typedef struct packed {
        logic                     en;
        logic signed [DIFF_W-1:0] operand;
    } t_sq_cmd;

    typedef struct packed {
        logic h;
        logic w;
    } t_grad_mode;

endpackage

### design/tml_store.sv
// ----------------------------------------------------------------------------
// tml_store
// difference memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module tml_store
    import tml_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_diff_pair        i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_diff_pair        o_rd_data
);

    t_diff_pair r_mem [DEPTH];
    t_diff_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/tml_sq.sv
// ----------------------------------------------------------------------------
// tml_sq
// shared squaring unit, one registered product per command
// ----------------------------------------------------------------------------
module tml_sq
    import tml_pkg::*;
(
    input  logic              i_clk,
    input  t_sq_cmd           i_cmd,
    output logic [PROD_W-1:0] o_product
);

    logic signed [PROD_W-1:0] w_square;
    logic [PROD_W-1:0]        r_product;

    assign w_square = PROD_W'(i_cmd.operand) * PROD_W'(i_cmd.operand);

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_product <= w_square;
        end
    end

    assign o_product = r_product;

endmodule

### design/tml_grad.sv
// ----------------------------------------------------------------------------
// tml_grad
// per-element gradients from the stored differences and hinge flags
// ----------------------------------------------------------------------------
module tml_grad
    import tml_pkg::*;
(
    input  t_diff_pair               i_diff,
    input  t_grad_mode               i_mode,
    output logic signed [GRAD_W-1:0] o_grad_anchor,
    output logic signed [GRAD_W-1:0] o_grad_positive,
    output logic signed [GRAD_W-1:0] o_grad_negative
);

    localparam int WIDE_W = GRAD_W + 1;

    logic signed [WIDE_W-1:0] w_dp2;
    logic signed [WIDE_W-1:0] w_dn2;
    logic signed [WIDE_W-1:0] w_extra;
    logic signed [WIDE_W-1:0] w_neg_term;
    logic signed [WIDE_W-1:0] w_ga;
    logic signed [WIDE_W-1:0] w_gp;

    function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(2 ** (GRAD_W - 1) - 1);
        lo = -WIDE_W'(2 ** (GRAD_W - 1));
        if (v > hi) begin
            sat_grad = hi[GRAD_W-1:0];
        end else if (v < lo) begin
            sat_grad = lo[GRAD_W-1:0];
        end else begin
            sat_grad = v[GRAD_W-1:0];
        end
    endfunction

    assign w_dp2      = {{(WIDE_W-DIFF_W-1){i_diff.dp[DIFF_W-1]}}, i_diff.dp, 1'b0};
    assign w_dn2      = {{(WIDE_W-DIFF_W-1){i_diff.dn[DIFF_W-1]}}, i_diff.dn, 1'b0};
    assign w_extra    = (i_mode.h && i_mode.w) ? w_dp2 : '0;
    assign w_neg_term = i_mode.h ? w_dn2 : '0;
    assign w_ga       = w_dp2 + w_extra - w_neg_term;
    assign w_gp       = -w_dp2 - w_extra;

    assign o_grad_anchor   = sat_grad(w_ga);
    assign o_grad_positive = sat_grad(w_gp);
    assign o_grad_negative = sat_grad(w_neg_term);

endmodule

### design/triplet_margin_loss_with_gradient.sv
// ----------------------------------------------------------------------------
// triplet_margin_loss_with_gradient
// streamed triplet margin loss with per-element gradients
// ----------------------------------------------------------------------------
// One element of the anchor, positive and negative vectors is taken per
// start while busy is low. Each element takes the accept step and two
// passes through the single shared squaring multiplier, which forms
// (a-p)^2 and then (a-n)^2. On an element marked final the block runs
// the loss arithmetic in states LOSS1, LOSS2 and LOSS3, then emits the
// loss word followed by one gradient word per stored element, since the
// difference memory read port delivers one element per cycle. Result
// words are valid for one cycle only and cannot be stalled.
// Elements beyond VECTOR_LEN_MAX in one sample are dropped.
// ----------------------------------------------------------------------------
module triplet_margin_loss_with_gradient
    import tml_pkg::*;
#(
    parameter int VECTOR_LEN_MAX = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [VAL_W-1:0]  i_anchor_value,
    input  logic signed [VAL_W-1:0]  i_positive_value,
    input  logic signed [VAL_W-1:0]  i_negative_value,
    input  logic                     i_final_element,
    output logic                     o_result_valid,
    output logic                     o_result_kind,
    output logic [LOSS_W-1:0]        o_loss_value,
    output logic [CNT_W-1:0]         o_element_index,
    output logic signed [GRAD_W-1:0] o_grad_anchor,
    output logic signed [GRAD_W-1:0] o_grad_positive,
    output logic signed [GRAD_W-1:0] o_grad_negative,
    output logic                     o_run_end,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    localparam int ADDR_W = (VECTOR_LEN_MAX > 1) ? $clog2(VECTOR_LEN_MAX) : 1;
    localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(VECTOR_LEN_MAX);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MULP  = 7'b0000010,
        S_MULN  = 7'b0000100,
        S_LOSS1 = 7'b0001000,
        S_LOSS2 = 7'b0010000,
        S_LOSS3 = 7'b0100000,
        S_GRAD  = 7'b1000000
    } t_state;

    t_state                   r_state, n_state;
    logic [DIST_W-1:0]        r_margin;
    logic [DIST_W-1:0]        r_pos_sum, n_pos_sum;
    logic [DIST_W-1:0]        r_neg_sum, n_neg_sum;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_k, n_k;
    logic                     r_pend, n_pend;
    logic signed [DIFF_W-1:0] r_dp, n_dp;
    logic signed [DIFF_W-1:0] r_dn, n_dn;
    logic                     r_last, n_last;
    logic                     r_inc, n_inc;
    logic [LOSS_W-1:0]        r_sum, n_sum;
    logic [LOSS_W-1:0]        r_hinge, n_hinge;
    logic                     r_h, n_h;
    logic                     r_w, n_w;

    logic                     r_valid, n_valid;
    logic                     r_kind, n_kind;
    logic [LOSS_W-1:0]        r_loss, n_loss;
    logic [CNT_W-1:0]         r_index, n_index;
    logic signed [GRAD_W-1:0] r_ga, n_ga;
    logic signed [GRAD_W-1:0] r_gp, n_gp;
    logic signed [GRAD_W-1:0] r_gn, n_gn;
    logic                     r_run_end, n_run_end;

    logic                     w_accept;
    logic                     w_cfg_wr;
    logic                     w_wr_en;
    t_diff_pair               w_wr_data;
    t_diff_pair               w_rd_data;
    logic [CNT_W-1:0]         w_k_next;
    logic [ADDR_W-1:0]        w_rd_addr;
    t_sq_cmd                  w_sq_cmd;
    logic [PROD_W-1:0]        w_product;
    t_grad_mode               w_mode;
    logic signed [GRAD_W-1:0] w_ga, w_gp, w_gn;
    logic [LOSS_W:0]          w_loss_full;
    logic [DIST_W-1:0]        w_min;

    assign w_accept  = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign w_cfg_wr  = psel && penable && pwrite && pready && (paddr == ADDR_MARGIN);
    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_MARGIN) ? APB_DW'(r_margin) : '0;

    assign w_wr_data.dp = DIFF_W'(i_anchor_value) - DIFF_W'(i_positive_value);
    assign w_wr_data.dn = DIFF_W'(i_anchor_value) - DIFF_W'(i_negative_value);
    assign w_wr_en      = w_accept && (r_count < LEN_MAX);

    assign w_k_next  = r_k + CNT_W'(1);
    assign w_rd_addr = (r_state == S_GRAD && w_k_next < LEN_MAX) ? w_k_next[ADDR_W-1:0] : '0;

    assign w_sq_cmd.en      = (r_state == S_MULP) || (r_state == S_MULN);
    assign w_sq_cmd.operand = (r_state == S_MULN) ? r_dn : r_dp;

    assign w_mode.h = r_h;
    assign w_mode.w = r_w;

    assign w_min       = (r_pos_sum < r_margin) ? r_pos_sum : r_margin;
    assign w_loss_full = (LOSS_W + 1)'(r_hinge) + (LOSS_W + 1)'(r_pos_sum);

    tml_store #(
        .DEPTH  (VECTOR_LEN_MAX),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    tml_sq u_sq (
        .i_clk     (i_clk),
        .i_cmd     (w_sq_cmd),
        .o_product (w_product)
    );

    tml_grad u_grad (
        .i_diff          (w_rd_data),
        .i_mode          (w_mode),
        .o_grad_anchor   (w_ga),
        .o_grad_positive (w_gp),
        .o_grad_negative (w_gn)
    );

    always_comb begin
        n_state   = r_state;
        n_pos_sum = r_pos_sum;
        n_neg_sum = r_neg_sum;
        n_count   = r_count;
        n_k       = r_k;
        n_pend    = 1'b0;
        n_dp      = r_dp;
        n_dn      = r_dn;
        n_last    = r_last;
        n_inc     = r_inc;
        n_sum     = r_sum;
        n_hinge   = r_hinge;
        n_h       = r_h;
        n_w       = r_w;
        n_valid   = 1'b0;
        n_kind    = r_kind;
        n_loss    = r_loss;
        n_index   = r_index;
        n_ga      = r_ga;
        n_gp      = r_gp;
        n_gn      = r_gn;
        n_run_end = r_run_end;

        // deferred add of the second square
        if (r_pend) begin
            n_neg_sum = r_neg_sum + DIST_W'(w_product);
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_dp    = w_wr_data.dp;
                    n_dn    = w_wr_data.dn;
                    n_last  = i_final_element;
                    n_inc   = w_wr_en;
                    if (w_wr_en) begin
                        n_count = r_count + CNT_W'(1);
                    end
                    n_state = S_MULP;
                end
            end
            S_MULP: begin
                n_state = S_MULN;
            end
            S_MULN: begin
                if (r_inc) begin
                    n_pos_sum = r_pos_sum + DIST_W'(w_product);
                end
                n_pend  = r_inc;
                n_state = r_last ? S_LOSS1 : S_IDLE;
            end
            S_LOSS1: begin
                n_sum   = LOSS_W'(w_min) + LOSS_W'(r_margin);
                n_w     = (r_pos_sum <= r_margin);
                n_state = S_LOSS2;
            end
            S_LOSS2: begin
                n_h     = (r_sum > LOSS_W'(r_neg_sum));
                n_hinge = n_h ? (r_sum - LOSS_W'(r_neg_sum)) : '0;
                n_state = S_LOSS3;
            end
            S_LOSS3: begin
                n_valid   = 1'b1;
                n_kind    = KIND_LOSS;
                n_loss    = w_loss_full[LOSS_W] ? '1 : w_loss_full[LOSS_W-1:0];
                n_index   = '0;
                n_ga      = '0;
                n_gp      = '0;
                n_gn      = '0;
                n_run_end = (r_count == '0);
                n_k       = '0;
                if (r_count == '0) begin
                    n_pos_sum = '0;
                    n_neg_sum = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_state   = S_GRAD;
                end
            end
            S_GRAD: begin
                n_valid   = 1'b1;
                n_kind    = KIND_GRAD;
                n_loss    = '0;
                n_index   = r_k;
                n_ga      = w_ga;
                n_gp      = w_gp;
                n_gn      = w_gn;
                n_run_end = (w_k_next == r_count);
                n_k       = w_k_next;
                if (w_k_next == r_count) begin
                    n_pos_sum = '0;
                    n_neg_sum = '0;
                    n_count   = '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_margin  <= MARGIN_RESET;
            r_pos_sum <= '0;
            r_neg_sum <= '0;
            r_count   <= '0;
            r_k       <= '0;
            r_pend    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos_sum <= n_pos_sum;
            r_neg_sum <= n_neg_sum;
            r_count   <= n_count;
            r_k       <= n_k;
            r_pend    <= n_pend;
            r_valid   <= n_valid;
            if (w_cfg_wr) begin
                r_margin <= pwdata[DIST_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dp      <= n_dp;
        r_dn      <= n_dn;
        r_last    <= n_last;
        r_inc     <= n_inc;
        r_sum     <= n_sum;
        r_hinge   <= n_hinge;
        r_h       <= n_h;
        r_w       <= n_w;
        r_kind    <= n_kind;
        r_loss    <= n_loss;
        r_index   <= n_index;
        r_ga      <= n_ga;
        r_gp      <= n_gp;
        r_gn      <= n_gn;
        r_run_end <= n_run_end;
    end

    assign o_result_valid  = r_valid;
    assign o_result_kind   = r_kind;
    assign o_loss_value    = r_loss;
    assign o_element_index = r_index;
    assign o_grad_anchor   = r_ga;
    assign o_grad_positive = r_gp;
    assign o_grad_negative = r_gn;
    assign o_run_end       = r_run_end;

`include "triplet_margin_loss_with_gradient_macros.svh"

    `TML_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, w_accept, busy, "busy not raised after start")
    `TML_ASSERT_NOW(a_loss_first, i_clk, i_rst_n, $rose(o_result_valid), o_result_kind == KIND_LOSS, "run does not open with loss word")
    `TML_ASSERT_NEXT(a_grad_sequence, i_clk, i_rst_n, o_result_valid && o_result_kind == KIND_GRAD && !o_run_end, o_result_valid && o_result_kind == KIND_GRAD && o_element_index == $past(o_element_index) + 6'd1, "gradient words not consecutive")
    `TML_ASSERT_NEXT(a_gap_after_run, i_clk, i_rst_n, o_result_valid && o_run_end, !o_result_valid, "word after run end")

endmodule

### verif/tml_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tml_checker
// Watches the element, result and register traffic of the triplet margin
// loss block. It keeps its own copy of the margin, the stored differences
// and the two distance sums. From these it predicts the loss word and the
// gradient words of every sample, then compares each result word with the
// oldest prediction, field by field. It also checks register reads.
// ----------------------------------------------------------------------------
module tml_checker
    import tml_pkg::*;
#(
    parameter int VECTOR_LEN_MAX = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic signed [VAL_W-1:0]  i_anchor_value,
    input  logic signed [VAL_W-1:0]  i_positive_value,
    input  logic signed [VAL_W-1:0]  i_negative_value,
    input  logic                     i_final_element,
    input  logic                     i_result_valid,
    input  logic                     i_result_kind,
    input  logic [LOSS_W-1:0]        i_loss_value,
    input  logic [CNT_W-1:0]         i_element_index,
    input  logic signed [GRAD_W-1:0] i_grad_anchor,
    input  logic signed [GRAD_W-1:0] i_grad_positive,
    input  logic signed [GRAD_W-1:0] i_grad_negative,
    input  logic                     i_run_end,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic [APB_AW-1:0]        i_paddr,
    input  logic [APB_DW-1:0]        i_pwdata,
    input  logic [APB_DW-1:0]        i_prdata,
    input  logic                     i_pready,
    output int                       o_fail_count,
    output int                       o_words_outstanding
);

    localparam longint LOSS_CAP = (longint'(1) << LOSS_W) - 1;
    localparam longint GRAD_HI  = (longint'(1) << (GRAD_W - 1)) - 1;
    localparam longint GRAD_LO  = -(longint'(1) << (GRAD_W - 1));

    typedef struct {
        logic                     kind;
        logic [LOSS_W-1:0]        loss;
        logic [CNT_W-1:0]         index;
        logic signed [GRAD_W-1:0] ga;
        logic signed [GRAD_W-1:0] gp;
        logic signed [GRAD_W-1:0] gn;
        logic                     run_end;
    } t_loss_grad_word;

    t_loss_grad_word          words_due[$];
    t_loss_grad_word          oldest_word;
    logic [DIST_W-1:0]        margin_copy;
    logic signed [DIFF_W-1:0] pos_diff[VECTOR_LEN_MAX];
    logic signed [DIFF_W-1:0] neg_diff[VECTOR_LEN_MAX];
    logic [DIST_W-1:0]        pos_dist;
    logic [DIST_W-1:0]        neg_dist;
    int                       stored_count;
    int                       fail_count = 0;

    function automatic logic signed [GRAD_W-1:0] clip_grad(input longint g);
        if (g > GRAD_HI) begin
            return GRAD_W'(GRAD_HI);
        end
        if (g < GRAD_LO) begin
            return GRAD_W'(GRAD_LO);
        end
        return GRAD_W'(g);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, $signed(want), $signed(got));
            fail_count++;
        end
    endfunction

    // store one element, and on the final one queue the loss and gradient words
    function automatic void fold_element(input logic signed [VAL_W-1:0] a,
                                         input logic signed [VAL_W-1:0] p,
                                         input logic signed [VAL_W-1:0] n,
                                         input logic last);
        longint          dp;
        longint          dn;
        longint          dpos;
        longint          dneg;
        longint          m;
        longint          hinge_arg;
        longint          loss;
        longint          ga;
        longint          gp;
        longint          gn;
        logic            h;
        logic            w;
        t_loss_grad_word wd;
        dp = longint'(a) - longint'(p);
        dn = longint'(a) - longint'(n);
        if (stored_count < VECTOR_LEN_MAX) begin
            pos_diff[stored_count] = DIFF_W'(dp);
            neg_diff[stored_count] = DIFF_W'(dn);
            pos_dist = DIST_W'(pos_dist + dp * dp);
            neg_dist = DIST_W'(neg_dist + dn * dn);
            stored_count++;
        end
        if (!last) begin
            return;
        end
        dpos = pos_dist;
        dneg = neg_dist;
        m    = margin_copy;
        hinge_arg = ((dpos < m) ? dpos : m) - dneg + m;
        h    = hinge_arg > 0;
        w    = dpos <= m;
        loss = (h ? hinge_arg : 0) + dpos;
        if (loss > LOSS_CAP) begin
            loss = LOSS_CAP;
        end
        wd.kind    = KIND_LOSS;
        wd.loss    = LOSS_W'(loss);
        wd.index   = '0;
        wd.ga      = '0;
        wd.gp      = '0;
        wd.gn      = '0;
        wd.run_end = stored_count == 0;
        words_due.insert(words_due.size(), wd);
        for (int k = 0; k < stored_count; k++) begin
            dp = longint'(pos_diff[k]);
            dn = longint'(neg_diff[k]);
            ga = 2 * dp;
            gp = -2 * dp;
            gn = 0;
            if (h) begin
                if (w) begin
                    ga += 2 * dp;
                    gp -= 2 * dp;
                end
                ga -= 2 * dn;
                gn = 2 * dn;
            end
            wd.kind    = KIND_GRAD;
            wd.loss    = '0;
            wd.index   = CNT_W'(k);
            wd.ga      = clip_grad(ga);
            wd.gp      = clip_grad(gp);
            wd.gn      = clip_grad(gn);
            wd.run_end = (k + 1) == stored_count;
            words_due.insert(words_due.size(), wd);
        end
        pos_dist     = '0;
        neg_dist     = '0;
        stored_count = 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            margin_copy  = MARGIN_RESET;
            pos_dist     = '0;
            neg_dist     = '0;
            stored_count = 0;
            words_due.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == ADDR_MARGIN) begin
                if (i_pwrite) begin
                    margin_copy = i_pwdata[DIST_W-1:0];
                end else begin
                    check_field("margin", margin_copy, i_prdata[DIST_W-1:0]);
                end
            end
            if (i_start && !i_busy) begin
                fold_element(i_anchor_value, i_positive_value, i_negative_value,
                             i_final_element);
            end
            if (i_result_valid) begin
                if (words_due.size() == 0) begin
                    $error("result word with none expected");
                    fail_count++;
                end else begin
                    oldest_word = words_due.pop_front();
                    check_field("result_kind", oldest_word.kind, i_result_kind);
                    check_field("loss_value", oldest_word.loss, i_loss_value);
                    check_field("element_index", oldest_word.index, i_element_index);
                    check_field("grad_anchor", oldest_word.ga, i_grad_anchor);
                    check_field("grad_positive", oldest_word.gp, i_grad_positive);
                    check_field("grad_negative", oldest_word.gn, i_grad_negative);
                    check_field("run_end", oldest_word.run_end, i_run_end);
                end
            end
        end
        o_fail_count        <= fail_count;
        o_words_outstanding <= words_due.size();
    end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the triplet margin loss block. It streams triplet samples
// one element per start: first a few hand-picked samples (zero, extreme and
// boundary values at the reset, zero and full margin), then random samples
// under several margin settings. Sample lengths mix short, long and
// overfull samples, and the gaps between elements are random. The checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
    import tml_pkg::*;

    localparam int VECTOR_LEN_MAX = 32;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 48;
    localparam int PHASE_ITEMS    = 35;
    localparam int PHASE_COUNT    = 6;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [VAL_W-1:0]  i_anchor_value = '0;
    logic signed [VAL_W-1:0]  i_positive_value = '0;
    logic signed [VAL_W-1:0]  i_negative_value = '0;
    logic                     i_final_element = 1'b0;
    logic                     o_result_valid;
    logic                     o_result_kind;
    logic [LOSS_W-1:0]        o_loss_value;
    logic [CNT_W-1:0]         o_element_index;
    logic signed [GRAD_W-1:0] o_grad_anchor;
    logic signed [GRAD_W-1:0] o_grad_positive;
    logic signed [GRAD_W-1:0] o_grad_negative;
    logic                     o_run_end;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_AW-1:0]        paddr = '0;
    logic [APB_DW-1:0]        pwdata = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    int fail_count;
    int words_outstanding;
    int cycle_count = 0;
    int items_sent = 0;
    bit no_gaps = 1'b0;

    always #10 i_clk = ~i_clk;

    triplet_margin_loss_with_gradient #(
        .VECTOR_LEN_MAX(VECTOR_LEN_MAX)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_anchor_value  (i_anchor_value),
        .i_positive_value(i_positive_value),
        .i_negative_value(i_negative_value),
        .i_final_element (i_final_element),
        .o_result_valid  (o_result_valid),
        .o_result_kind   (o_result_kind),
        .o_loss_value    (o_loss_value),
        .o_element_index (o_element_index),
        .o_grad_anchor   (o_grad_anchor),
        .o_grad_positive (o_grad_positive),
        .o_grad_negative (o_grad_negative),
        .o_run_end       (o_run_end),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    tml_checker #(
        .VECTOR_LEN_MAX(VECTOR_LEN_MAX)
    ) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_anchor_value     (i_anchor_value),
        .i_positive_value   (i_positive_value),
        .i_negative_value   (i_negative_value),
        .i_final_element    (i_final_element),
        .i_result_valid     (o_result_valid),
        .i_result_kind      (o_result_kind),
        .i_loss_value       (o_loss_value),
        .i_element_index    (o_element_index),
        .i_grad_anchor      (o_grad_anchor),
        .i_grad_positive    (o_grad_positive),
        .i_grad_negative    (o_grad_negative),
        .i_run_end          (o_run_end),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .i_prdata           (prdata),
        .i_pready           (pready),
        .o_fail_count       (fail_count),
        .o_words_outstanding(words_outstanding)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_element(input logic signed [VAL_W-1:0] a,
                                input logic signed [VAL_W-1:0] p,
                                input logic signed [VAL_W-1:0] n,
                                input logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_anchor_value   <= a;
        i_positive_value <= p;
        i_negative_value <= n;
        i_final_element  <= last;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // hold off until every word of the last sample is out and the block is idle
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (words_outstanding != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_margin(input logic [DIST_W-1:0] value);
        settle();
        apb_access(1'b1, ADDR_MARGIN, APB_DW'(value));
        apb_access(1'b0, ADDR_MARGIN, '0);
    endtask

    function automatic logic signed [VAL_W-1:0] rand_val(input int mode);
        case (mode)
            0: return VAL_W'($urandom);
            1: return VAL_W'(int'($urandom_range(0, 1200)) - 600);
            default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_near(input logic signed [VAL_W-1:0] a,
                                                          input int mode);
        if ($urandom_range(0, 1) == 0) begin
            return rand_val(mode);
        end
        return VAL_W'(int'(a) + int'($urandom_range(0, 64)) - 32);
    endfunction

    task automatic send_sample(input int len);
        int                      mode;
        logic signed [VAL_W-1:0] a;
        mode    = $urandom_range(0, 4) % 3;
        no_gaps = $urandom_range(0, 3) == 0;
        for (int e = 0; e < len; e++) begin
            a = rand_val(mode);
            send_element(a, rand_near(a, mode), rand_near(a, mode), e == len - 1);
        end
    endtask

    function automatic logic [DIST_W-1:0] pick_margin(input int phase);
        case (phase % 5)
            0: return DIST_W'($urandom_range(0, 1 << 22));
            1: return {8'($urandom_range(0, 255)), 32'($urandom)};
            2: return '1;
            3: return '0;
            default: return DIST_W'($urandom);
        endcase
    endfunction

    initial begin
        int len;
        int phase_start;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_access(1'b0, ADDR_MARGIN, '0);

        // reset margin: all zero, extremes, hinge exactly at zero, small diffs
        send_element(16'sd0, 16'sd0, 16'sd0, 1'b1);
        send_element(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
        send_element(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
        send_element(16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1);
        send_element(16'sd256, 16'sd256, 16'sd0, 1'b1);
        send_element(16'sd256, 16'sd255, 16'sd250, 1'b0);
        send_element(-16'sd256, -16'sd250, -16'sd200, 1'b1);

        set_margin('0);
        send_element(16'sd100, 16'sd90, 16'sd80, 1'b1);
        send_element(16'sd0, 16'sd0, 16'sd0, 1'b1);

        set_margin('1);
        repeat (4) send_element(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
        send_element(16'sh8000, 16'sh7fff, 16'sh7fff, 1'b1);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            set_margin(pick_margin(phase));
            phase_start = items_sent;
            if (phase == 1) begin
                send_sample(VECTOR_LEN_MAX + 3);
            end
            while (items_sent - phase_start < PHASE_ITEMS) begin
                case ($urandom_range(0, 19))
                    0:       len = $urandom_range(VECTOR_LEN_MAX + 1, VECTOR_LEN_MAX + 3);
                    1, 2, 3: len = $urandom_range(7, VECTOR_LEN_MAX);
                    default: len = $urandom_range(1, 6);
                endcase
                send_sample(len);
                if ($urandom_range(0, 9) == 0) begin
                    settle();
                end
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
